// ===== hdl/fpqd_pkg.sv =====
// ----------------------------------------------------------------------------
// fpqd_pkg - shared definitions for the ready-queue dispatcher
// Action and status codes, the queue entry type, saturation limits and
// the ordering rule used when a priority insert walks the queue.
// ----------------------------------------------------------------------------
package fpqd_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  // action codes
  localparam logic [1:0] ACT_INSERT   = 2'd0;
  localparam logic [1:0] ACT_DISPATCH = 2'd1;
  localparam logic [1:0] ACT_CLEAR    = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_EMPTY   = 2'd2;
  localparam logic [1:0] STAT_CLEARED = 2'd3;

  localparam logic [47:0] MAX32 = 48'h0000_FFFF_FFFF;
  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0] DONE_MAX = 16'hFFFF;

  typedef logic [4:0] fill_t;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  pri;
    logic [15:0] burst;
  } entry_t;

  // new entry goes in front of e when it has higher priority, or equal
  // priority and a lower id
  function automatic logic beats(input entry_t n, input entry_t e);
    return (n.pri > e.pri) || ((n.pri == e.pri) && (n.id < e.id));
  endfunction

endpackage

// ===== hdl/fpqd_ram.sv =====
// ----------------------------------------------------------------------------
// fpqd_ram - generic single-write, single-read memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fpqd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ===== hdl/fpqd_satadd.sv =====
// ----------------------------------------------------------------------------
// fpqd_satadd - shared saturating adder
// One 48-bit add with a selectable ceiling of 2^32-1 or 2^48-1; the
// sequencer uses it for the new clock and for both running totals.
// ----------------------------------------------------------------------------
module fpqd_satadd (
  input  logic [47:0] a,
  input  logic [47:0] b,
  input  logic        wide,
  output logic [47:0] y
);

  logic [48:0] sum;
  logic [48:0] limit;

  always_comb begin
    sum   = {1'b0, a} + {1'b0, b};
    limit = wide ? {1'b0, fpqd_pkg::MAX48} : {1'b0, fpqd_pkg::MAX32};
    if (sum > limit) begin
      y = limit[47:0];
    end else begin
      y = sum[47:0];
    end
  end

endmodule

// ===== hdl/fcfs_priority_ready_queue_dispatcher.sv =====
// ----------------------------------------------------------------------------
// fcfs_priority_ready_queue_dispatcher - non-preemptive FCFS/priority dispatcher
// Ready queue in a circular RAM, one sequencer and one shared saturating adder.
// ----------------------------------------------------------------------------
// The ready queue lives in a single-port-read RAM addressed as a ring, so a
// dispatch only moves the head pointer. An item is taken when the sequencer
// is idle; the result then waits in an output register while the next item
// is already accepted. Per item up to a loaded result: an insert in FCFS mode
// or into an empty queue writes the tail; a priority insert walks the N queued
// entries (a read state, then an evaluate-and-rewrite state, for each entry,
// as the RAM read is registered) and then writes the tail; a dispatch reads
// the head, then makes one adder pass each for clock, waiting total and turnaround total; other items go straight out.
// ----------------------------------------------------------------------------
module fcfs_priority_ready_queue_dispatcher #(
  parameter int QUEUE_DEPTH = fpqd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_priority_mode,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_proc_id,
  input  logic [7:0]  in_proc_priority,
  input  logic [15:0] in_proc_burst,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [15:0] out_run_id,
  output logic [31:0] out_start_time,
  output logic [31:0] out_finish_time,
  output logic [31:0] out_waiting_time,
  output logic [31:0] out_turnaround_time,
  output logic [47:0] out_total_waiting,
  output logic [47:0] out_total_turnaround,
  output logic [15:0] out_done_count,
  output logic [4:0]  out_queue_fill
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = $bits(fpqd_pkg::entry_t);
  localparam logic [AW:0]   DEPTH_W = (AW + 1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [AW-1:0] HEAD_LAST = AW'(QUEUE_DEPTH - 1);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_SCAN_RD = 4'd1;
  localparam logic [3:0] ST_SCAN_EV = 4'd2;
  localparam logic [3:0] ST_TAIL    = 4'd3;
  localparam logic [3:0] ST_D_RD    = 4'd4;
  localparam logic [3:0] ST_D_FIN   = 4'd5;
  localparam logic [3:0] ST_D_SW    = 4'd6;
  localparam logic [3:0] ST_D_ST    = 4'd7;
  localparam logic [3:0] ST_EMIT    = 4'd8;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[AW-1:0];
  endfunction

  // control state
  logic [3:0]    state_r, state_nxt;
  logic          prio_mode_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [31:0]   clock_r, clock_nxt;
  logic [47:0]   sum_w_r, sum_w_nxt;
  logic [47:0]   sum_t_r, sum_t_nxt;
  logic [15:0]   done_r, done_nxt;
  logic          out_valid_r, out_valid_nxt;

  // working payload
  logic [CW-1:0]        k_r, k_nxt;
  logic                 shifting_r, shifting_nxt;
  fpqd_pkg::entry_t     carry_r, carry_nxt;
  logic [1:0]           status_r, status_nxt;
  logic [15:0]          rid_r, rid_nxt;
  logic [31:0]          start_r, start_nxt;
  logic [31:0]          finish_r, finish_nxt;

  // result register
  logic [1:0]  o_status_r;
  logic [15:0] o_rid_r;
  logic [31:0] o_start_r;
  logic [31:0] o_finish_r;
  logic [47:0] o_sum_w_r;
  logic [47:0] o_sum_t_r;
  logic [15:0] o_done_r;
  logic [4:0]  o_fill_r;
  logic        o_load;

  // RAM and adder hookup
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [EW-1:0]    ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [EW-1:0]    ram_rdata;
  fpqd_pkg::entry_t rd_entry;
  logic [47:0]      add_a, add_b, add_y;
  logic             add_wide;
  logic             in_acc;
  logic             beat;

  fpqd_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fpqd_satadd u_satadd (
    .a    (add_a),
    .b    (add_b),
    .wide (add_wide),
    .y    (add_y)
  );

  assign rd_entry = fpqd_pkg::entry_t'(ram_rdata);
  // hold off transactions while in reset
  assign in_stall = !rst_n || (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign beat     = shifting_r || fpqd_pkg::beats(carry_r, rd_entry);

  always_comb begin
    unique case (state_r)
      ST_D_FIN: begin
        add_a    = {16'd0, clock_r};
        add_b    = {32'd0, rd_entry.burst};
        add_wide = 1'b0;
      end
      ST_D_SW: begin
        add_a    = sum_w_r;
        add_b    = {16'd0, start_r};
        add_wide = 1'b1;
      end
      default: begin
        add_a    = sum_t_r;
        add_b    = {16'd0, finish_r};
        add_wide = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    head_nxt      = head_r;
    clock_nxt     = clock_r;
    sum_w_nxt     = sum_w_r;
    sum_t_nxt     = sum_t_r;
    done_nxt      = done_r;
    k_nxt         = k_r;
    shifting_nxt  = shifting_r;
    carry_nxt     = carry_r;
    status_nxt    = status_r;
    rid_nxt       = rid_r;
    start_nxt     = start_r;
    finish_nxt    = finish_r;
    out_valid_nxt = out_valid_r;
    o_load        = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = phys(head_r, k_r[AW-1:0]);
    ram_wdata     = carry_r;
    ram_re        = 1'b0;
    ram_raddr     = phys(head_r, k_r[AW-1:0]);

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          rid_nxt      = '0;
          start_nxt    = '0;
          finish_nxt   = '0;
          k_nxt        = '0;
          shifting_nxt = 1'b0;
          carry_nxt    = '{id: in_proc_id, pri: in_proc_priority, burst: in_proc_burst};
          status_nxt   = fpqd_pkg::STAT_OK;
          state_nxt    = ST_EMIT;
          unique case (in_action)
            fpqd_pkg::ACT_INSERT: begin
              if (count_r >= DEPTH_C) begin
                status_nxt = fpqd_pkg::STAT_FULL;
              end else if (prio_mode_r && (count_r != '0)) begin
                state_nxt = ST_SCAN_RD;
              end else begin
                state_nxt = ST_TAIL;
              end
            end
            fpqd_pkg::ACT_DISPATCH: begin
              if (count_r == '0) begin
                status_nxt = fpqd_pkg::STAT_EMPTY;
              end else begin
                state_nxt = ST_D_RD;
              end
            end
            fpqd_pkg::ACT_CLEAR: begin
              count_nxt  = '0;
              head_nxt   = '0;
              clock_nxt  = '0;
              sum_w_nxt  = '0;
              sum_t_nxt  = '0;
              done_nxt   = '0;
              status_nxt = fpqd_pkg::STAT_CLEARED;
            end
            default: begin
              status_nxt = fpqd_pkg::STAT_OK;
            end
          endcase
        end
      end
      ST_SCAN_RD: begin
        ram_re    = 1'b1;
        state_nxt = ST_SCAN_EV;
      end
      ST_SCAN_EV: begin
        // once the slot is found, ripple every later entry one place back
        if (beat) begin
          ram_we       = 1'b1;
          carry_nxt    = rd_entry;
          shifting_nxt = 1'b1;
        end
        k_nxt = k_r + 1'b1;
        if ((k_r + 1'b1) == count_r) begin
          state_nxt = ST_TAIL;
        end else begin
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_TAIL: begin
        ram_we    = 1'b1;
        ram_waddr = phys(head_r, count_r[AW-1:0]);
        count_nxt = count_r + 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_D_RD: begin
        ram_re    = 1'b1;
        ram_raddr = head_r;
        state_nxt = ST_D_FIN;
      end
      ST_D_FIN: begin
        rid_nxt    = rd_entry.id;
        start_nxt  = clock_r;
        finish_nxt = add_y[31:0];
        clock_nxt  = add_y[31:0];
        head_nxt   = (head_r == HEAD_LAST) ? '0 : head_r + 1'b1;
        count_nxt  = count_r - 1'b1;
        if (done_r != fpqd_pkg::DONE_MAX) begin
          done_nxt = done_r + 1'b1;
        end
        state_nxt = ST_D_SW;
      end
      ST_D_SW: begin
        sum_w_nxt = add_y;
        state_nxt = ST_D_ST;
      end
      ST_D_ST: begin
        sum_t_nxt = add_y;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          o_load        = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prio_mode_r <= 1'b0;
      count_r     <= '0;
      head_r      <= '0;
      clock_r     <= '0;
      sum_w_r     <= '0;
      sum_t_r     <= '0;
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      clock_r     <= clock_nxt;
      sum_w_r     <= sum_w_nxt;
      sum_t_r     <= sum_t_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        prio_mode_r <= cfg_priority_mode;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    shifting_r <= shifting_nxt;
    carry_r    <= carry_nxt;
    status_r   <= status_nxt;
    rid_r      <= rid_nxt;
    start_r    <= start_nxt;
    finish_r   <= finish_nxt;
    if (o_load) begin
      o_status_r <= status_r;
      o_rid_r    <= rid_r;
      o_start_r  <= start_r;
      o_finish_r <= finish_r;
      o_sum_w_r  <= sum_w_r;
      o_sum_t_r  <= sum_t_r;
      o_done_r   <= done_r;
      o_fill_r   <= fpqd_pkg::fill_t'(count_r);
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = o_status_r;
  assign out_run_id           = o_rid_r;
  assign out_start_time       = o_start_r;
  assign out_finish_time      = o_finish_r;
  assign out_waiting_time     = o_start_r;
  assign out_turnaround_time  = o_finish_r;
  assign out_total_waiting    = o_sum_w_r;
  assign out_total_turnaround = o_sum_t_r;
  assign out_done_count       = o_done_r;
  assign out_queue_fill       = o_fill_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("queue count beyond depth");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, head_r} < DEPTH_W)
    else $error("head pointer out of range");

  a_scan_in_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN_EV) |-> (k_r < count_r))
    else $error("scan index past queue tail");

  a_no_write_on_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_D_RD || state_r == ST_D_FIN || state_r == ST_D_SW ||
     state_r == ST_D_ST) |-> !ram_we)
    else $error("queue written during dispatch");

  a_finish_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (o_finish_r >= o_start_r))
    else $error("finish time before start time");

endmodule

// ===== sim/fcfs_priority_ready_queue_dispatcher_test.sv =====
// ----------------------------------------------------------------------------
// fcfs_priority_ready_queue_dispatcher_test - dispatcher scheduling check
// Drives insert, dispatch, clear and unused actions through the valid/stall
// channel and keeps its own ready queue, clock and totals to predict each
// result. Every result is compared field by field, in order, under random
// sender gaps and receiver stalls, in both queue-order modes.
// ----------------------------------------------------------------------------
module fcfs_priority_ready_queue_dispatcher_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ACT_NOP = 2'd3;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int ITEMS_PER_PHASE = 300;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] run_id;
    logic [31:0] start_val;
    logic [31:0] finish_val;
    logic [31:0] wait_val;
    logic [31:0] tat_val;
    logic [47:0] total_waiting;
    logic [47:0] tat_total;
    logic [15:0] done_count;
    logic [4:0]  queue_fill;
  } sched_result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_priority_mode;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_action;
  logic [15:0] in_proc_id;
  logic [7:0]  in_proc_priority;
  logic [15:0] in_proc_burst;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [15:0] out_run_id;
  logic [31:0] out_start_time;
  logic [31:0] out_finish_time;
  logic [31:0] out_waiting_time;
  logic [31:0] out_turnaround_time;
  logic [47:0] out_total_waiting;
  logic [47:0] out_total_turnaround;
  logic [15:0] out_done_count;
  logic [4:0]  out_queue_fill;

  // scheduler state as the block should hold it
  fpqd_pkg::entry_t ready_q[$];
  logic        sched_mode = 1'b0;
  logic [31:0] clock_now = '0;
  logic [47:0] sum_waiting = '0;
  logic [47:0] sum_turnaround = '0;
  logic [15:0] done_total = '0;

  sched_result_t pending_results[$];
  int            n_fail = 0;
  int            cycle_count = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;

  fcfs_priority_ready_queue_dispatcher dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_priority_mode   (cfg_priority_mode),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_proc_id          (in_proc_id),
    .in_proc_priority    (in_proc_priority),
    .in_proc_burst       (in_proc_burst),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_run_id          (out_run_id),
    .out_start_time      (out_start_time),
    .out_finish_time     (out_finish_time),
    .out_waiting_time    (out_waiting_time),
    .out_turnaround_time (out_turnaround_time),
    .out_total_waiting   (out_total_waiting),
    .out_total_turnaround(out_total_turnaround),
    .out_done_count      (out_done_count),
    .out_queue_fill      (out_queue_fill)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  function automatic logic [47:0] add_sat48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? fpqd_pkg::MAX48 : s[47:0];
  endfunction

  // advance the scheduler state by one transaction and return its result
  function automatic sched_result_t schedule_step(input logic [1:0] act,
                                                  input logic [15:0] id,
                                                  input logic [7:0] pri,
                                                  input logic [15:0] burst);
    sched_result_t    r;
    fpqd_pkg::entry_t e;
    int               pos;
    logic [32:0]      fin_wide;
    logic [31:0]      start;
    logic [31:0]      finish;
    r = '{default: '0};
    r.status = fpqd_pkg::STAT_OK;
    case (act)
      fpqd_pkg::ACT_INSERT: begin
        if (ready_q.size() >= fpqd_pkg::QUEUE_DEPTH_DEF) begin
          r.status = fpqd_pkg::STAT_FULL;
        end else begin
          e.id = id;
          e.pri = pri;
          e.burst = burst;
          pos = ready_q.size();
          if (sched_mode) begin
            for (int k = ready_q.size() - 1; k >= 0; k--) begin
              if (pri > ready_q[k].pri || (pri == ready_q[k].pri && id < ready_q[k].id))
                pos = k;
            end
          end
          ready_q.insert(pos, e);
        end
      end
      fpqd_pkg::ACT_DISPATCH: begin
        if (ready_q.size() == 0) begin
          r.status = fpqd_pkg::STAT_EMPTY;
        end else begin
          e = ready_q.pop_front();
          start = clock_now;
          fin_wide = {1'b0, start} + {17'b0, e.burst};
          finish = fin_wide[32] ? 32'hFFFF_FFFF : fin_wide[31:0];
          clock_now = finish;
          sum_waiting = add_sat48(sum_waiting, {16'b0, start});
          sum_turnaround = add_sat48(sum_turnaround, {16'b0, finish});
          if (done_total != fpqd_pkg::DONE_MAX) done_total++;
          r.run_id = e.id;
          r.start_val = start;
          r.finish_val = finish;
          r.wait_val = start;
          r.tat_val = finish;
        end
      end
      fpqd_pkg::ACT_CLEAR: begin
        ready_q.delete();
        clock_now = '0;
        sum_waiting = '0;
        sum_turnaround = '0;
        done_total = '0;
        r.status = fpqd_pkg::STAT_CLEARED;
      end
      default: begin
      end
    endcase
    r.total_waiting = sum_waiting;
    r.tat_total = sum_turnaround;
    r.done_count = done_total;
    r.queue_fill = 5'(ready_q.size());
    return r;
  endfunction

  task automatic check_field(input string name, input logic [47:0] exp_v,
                             input logic [47:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin
    sched_result_t r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no transaction outstanding: status 0x%0h", out_status);
        n_fail++;
      end else begin
        r = pending_results.pop_front();
        check_field("out_status", 48'(r.status), 48'(out_status));
        check_field("out_run_id", 48'(r.run_id), 48'(out_run_id));
        check_field("out_start_time", 48'(r.start_val), 48'(out_start_time));
        check_field("out_finish_time", 48'(r.finish_val), 48'(out_finish_time));
        check_field("out_waiting_time", 48'(r.wait_val), 48'(out_waiting_time));
        check_field("out_turnaround_time", 48'(r.tat_val), 48'(out_turnaround_time));
        check_field("out_total_waiting", r.total_waiting, out_total_waiting);
        check_field("out_total_turnaround", r.tat_total, out_total_turnaround);
        check_field("out_done_count", 48'(r.done_count), 48'(out_done_count));
        check_field("out_queue_fill", 48'(r.queue_fill), 48'(out_queue_fill));
      end
    end
  end

  // present one transaction after a random gap and hold it until taken
  task automatic send_item(input logic [1:0] act, input logic [15:0] id,
                           input logic [7:0] pri, input logic [15:0] burst);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_proc_id <= id;
    in_proc_priority <= pri;
    in_proc_burst <= burst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(schedule_step(act, id, pri, burst));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_mode(input logic m);
    drain_results();
    cfg_we <= 1'b1;
    cfg_priority_mode <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    sched_mode = m;
  endtask

  // small id and priority pools make ties common
  function automatic logic [15:0] pick_id();
    case ($urandom_range(0, 9))
      0, 1, 2: return 16'($urandom_range(0, 7));
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_pri();
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'($urandom_range(0, 3));
      3:       return 8'hFF;
      4:       return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_burst();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(1, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random(input logic [1:0] act);
    send_item(act, pick_id(), pick_pri(), pick_burst());
  endtask

  task automatic test_fcfs_order();
    set_mode(1'b0);
    send_item(fpqd_pkg::ACT_INSERT, 16'hFFFF, 8'h00, 16'hFFFF);
    send_item(fpqd_pkg::ACT_INSERT, 16'h0000, 8'hFF, 16'h0000);
    send_item(fpqd_pkg::ACT_INSERT, 16'h1234, 8'h80, 16'h0001);
    repeat (4) send_item(fpqd_pkg::ACT_DISPATCH, 16'h0000, 8'h00, 16'h0000);
    send_item(ACT_NOP, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_item(fpqd_pkg::ACT_CLEAR, 16'h0000, 8'h00, 16'h0000);
  endtask

  task automatic test_priority_order();
    set_mode(1'b1);
    send_item(fpqd_pkg::ACT_INSERT, 16'd9, 8'd4, 16'd10);
    send_item(fpqd_pkg::ACT_INSERT, 16'd3, 8'd4, 16'd20);
    send_item(fpqd_pkg::ACT_INSERT, 16'd3, 8'd4, 16'd30);
    send_item(fpqd_pkg::ACT_INSERT, 16'd7, 8'd200, 16'd5);
    send_item(fpqd_pkg::ACT_INSERT, 16'd1, 8'd0, 16'hFFFF);
    send_item(fpqd_pkg::ACT_DISPATCH, 16'd0, 8'd0, 16'd0);
    // switch order with entries queued: they keep their place
    set_mode(1'b0);
    send_item(fpqd_pkg::ACT_INSERT, 16'd0, 8'hFF, 16'd2);
    repeat (5) send_item(fpqd_pkg::ACT_DISPATCH, 16'd0, 8'd0, 16'd0);
    send_item(fpqd_pkg::ACT_CLEAR, 16'hFFFF, 8'hFF, 16'hFFFF);
  endtask

  task automatic test_queue_overflow();
    send_random(fpqd_pkg::ACT_CLEAR);
    repeat (fpqd_pkg::QUEUE_DEPTH_DEF + 2) send_random(fpqd_pkg::ACT_INSERT);
    send_random(fpqd_pkg::ACT_DISPATCH);
    send_random(fpqd_pkg::ACT_INSERT);
    send_random(fpqd_pkg::ACT_INSERT);
  endtask

  // runs of inserts and dispatches with random content, some noise between
  task automatic test_random_traffic(input int n_items);
    int sent;
    int run_len;
    int kind;
    for (int chunk = 0; chunk < n_items / 100; chunk++) begin
      set_mode(~sched_mode);
      sent = 0;
      while (sent < 100) begin
        kind = $urandom_range(0, 19);
        if (kind < 7) begin
          run_len = $urandom_range(4, 20);
          repeat (run_len) send_random(fpqd_pkg::ACT_INSERT);
          sent += run_len;
        end else if (kind < 14) begin
          run_len = $urandom_range(4, 18);
          repeat (run_len) send_random(fpqd_pkg::ACT_DISPATCH);
          sent += run_len;
        end else if (kind < 19) begin
          run_len = $urandom_range(4, 12);
          repeat (run_len) begin
            send_random($urandom_range(0, 1) ? fpqd_pkg::ACT_INSERT : fpqd_pkg::ACT_DISPATCH);
          end
          sent += run_len;
        end else begin
          case ($urandom_range(0, 2))
            0: begin
              send_random(fpqd_pkg::ACT_CLEAR);
              sent++;
            end
            1: send_random(ACT_NOP);
            default: begin
              send_random(fpqd_pkg::ACT_DISPATCH);
              sent++;
            end
          endcase
        end
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_priority_mode <= 1'b0;
    in_valid <= 1'b0;
    in_action <= fpqd_pkg::ACT_INSERT;
    in_proc_id <= '0;
    in_proc_priority <= '0;
    in_proc_burst <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 23;
    recv_idle_pct = 68;
    test_fcfs_order();
    test_priority_order();
    test_queue_overflow();
    test_random_traffic(ITEMS_PER_PHASE);

    send_idle_pct = 68;
    recv_idle_pct = 23;
    test_random_traffic(ITEMS_PER_PHASE);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(ITEMS_PER_PHASE);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (n_fail == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== fcfs_priority_ready_queue_dispatcher.f =====
hdl/fpqd_pkg.sv
hdl/fpqd_ram.sv
hdl/fpqd_satadd.sv
hdl/fcfs_priority_ready_queue_dispatcher.sv
sim/fcfs_priority_ready_queue_dispatcher_test.sv
